### hdl/gdrc_pkg.sv
// Shared types and constants for the grid DDA ray caster.
// No dependencies; used by every module under hdl/ except gdrc_div.
package gdrc_pkg;

	localparam int MAP_SIDE_DEF  = 64;
	localparam int MAX_STEPS_DEF = 128;
	localparam int DIV_W         = 31;   // shared divider operand width
	localparam int SIDE_W        = 49;   // Q16.16 side/delta accumulators, with headroom
	localparam int ADDR_W        = 5;    // APB byte address width

	localparam logic [2:0] REG_PLAYER_X = 3'd0;
	localparam logic [2:0] REG_PLAYER_Y = 3'd1;
	localparam logic [2:0] REG_DIR_X    = 3'd2;
	localparam logic [2:0] REG_DIR_Y    = 3'd3;
	localparam logic [2:0] REG_PLANE_X  = 3'd4;
	localparam logic [2:0] REG_PLANE_Y  = 3'd5;
	localparam logic [2:0] REG_COLS     = 3'd6;
	localparam logic [2:0] REG_ROWS     = 3'd7;

	localparam logic [15:0] RST_PLAYER_X = 16'd32768;
	localparam logic [15:0] RST_PLAYER_Y = 16'd32768;
	localparam logic [15:0] RST_DIR_X    = 16'd16384;
	localparam logic [15:0] RST_DIR_Y    = 16'd0;
	localparam logic [15:0] RST_PLANE_X  = 16'd0;
	localparam logic [15:0] RST_PLANE_Y  = 16'd10813;
	localparam logic [12:0] RST_COLS     = 13'd640;
	localparam logic [11:0] RST_ROWS     = 12'd480;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_CAST  = 1'b1;

	typedef struct packed {
		logic [15:0]        player_x;
		logic [15:0]        player_y;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] plane_x;
		logic signed [15:0] plane_y;
		logic [12:0]        cols;
		logic [11:0]        rows;
	} cfg_t;

	typedef struct packed {
		logic        cmd;
		logic [11:0] column;
		logic [5:0]  cell_x;
		logic [5:0]  cell_y;
		logic        wall;
	} item_t;

	typedef struct packed {
		logic [15:0] perp;
		logic [5:0]  hit_x;
		logic [5:0]  hit_y;
		logic        horiz;
		logic        neg_x;
		logic        neg_y;
		logic [15:0] lh;
		logic [10:0] ds;
		logic [10:0] de;
		logic        left;
	} res_t;

endpackage

### hdl/gdrc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing; shared by the cast engine in gdrc_back.
module gdrc_div #(
	parameter int W = 31
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         go,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient
);
	localparam int CNW = $clog2(W);

	logic [W-1:0]   rem_q, quo_q, div_q;
	logic [CNW-1:0] cnt_q;
	logic           run_q, done_q;
	logic [W:0]     trial;
	logic [W:0]     diff;

	assign trial = {rem_q, quo_q[W-1]};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNW'(W-1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (run_q) begin
			if (!diff[W]) begin
				rem_q <= diff[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

### hdl/gdrc_front.sv
// Front end: accepts command beats and holds them in a two-entry queue.
// Depends on gdrc_pkg.
module gdrc_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  gdrc_pkg::item_t in_item,
	input  logic            hold,
	output logic            busy,
	output gdrc_pkg::item_t q_item,
	output logic            q_valid,
	input  logic            q_pop
);
	gdrc_pkg::item_t ent_q [2];
	logic            wr_q, rd_q;
	logic [1:0]      cnt_q;
	logic            push;

	assign busy    = hold || (cnt_q == 2'd2);
	assign push    = start && !busy;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item  = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= in_item;
	end
endmodule

### hdl/gdrc_back.sv
// Back end: wall map memory, clear sweep, and the ray cast sequencer.
// Depends on gdrc_pkg and gdrc_div.
module gdrc_back #(
	parameter int MAP_SIDE  = gdrc_pkg::MAP_SIDE_DEF,
	parameter int MAX_STEPS = gdrc_pkg::MAX_STEPS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  gdrc_pkg::cfg_t  cfg,
	input  gdrc_pkg::item_t q_item,
	input  logic            q_valid,
	output logic            q_pop,
	output logic            clearing,
	output gdrc_pkg::res_t  res,
	output logic            res_valid
);
	localparam int CW    = ($clog2(MAP_SIDE) > 6) ? $clog2(MAP_SIDE) : 6;
	localparam int DEPTH = MAP_SIDE * MAP_SIDE;
	localparam int AW    = $clog2(DEPTH);
	localparam int NW    = $clog2(MAX_STEPS + 1);
	localparam int SW    = gdrc_pkg::SIDE_W;
	localparam int DW    = gdrc_pkg::DIV_W;

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_CAM  = 4'd2;
	localparam logic [3:0] S_MUL  = 4'd3;
	localparam logic [3:0] S_RAY  = 4'd4;
	localparam logic [3:0] S_DX   = 4'd5;
	localparam logic [3:0] S_DXW  = 4'd6;
	localparam logic [3:0] S_DY   = 4'd7;
	localparam logic [3:0] S_DYW  = 4'd8;
	localparam logic [3:0] S_SIDE = 4'd9;
	localparam logic [3:0] S_STEP = 4'd10;
	localparam logic [3:0] S_TEST = 4'd11;
	localparam logic [3:0] S_PERP = 4'd12;
	localparam logic [3:0] S_LH   = 4'd13;
	localparam logic [3:0] S_LHW  = 4'd14;
	localparam logic [3:0] S_OUT  = 4'd15;

	localparam logic [SW-1:0] ZERO_DELTA = SW'(1) << 40;

	logic [3:0]           state_q;
	logic [AW-1:0]        clr_q;
	logic                 map_q [DEPTH];
	logic                 rdata_q;

	logic signed [28:0]   cam_q;
	logic signed [44:0]   prodx_q, prody_q;
	logic signed [31:0]   rdx_q, rdy_q;
	logic                 nx_q, ny_q;
	logic [SW-1:0]        dx_q, dy_q, sx_q, sy_q;
	logic [CW-1:0]        mx_q, my_q;
	logic [NW-1:0]        n_q;
	logic                 horiz_q, left_q, stepped_q;
	logic [15:0]          perp_q, lh_q;
	gdrc_pkg::res_t       res_q;
	logic                 res_valid_q;

	logic [12:0]          cols_eff;
	logic [11:0]          rows_eff;
	logic                 div_go, div_done;
	logic [DW-1:0]        div_a, div_b, div_q;
	logic [31:0]          magx, magy;
	logic [10:0]          fracx, fracy;
	logic [41:0]          sprodx, sprody;
	logic [SW-1:0]        sidex, sidey;
	logic                 x_first, x_out, y_out;
	logic [CW-1:0]        mx_nxt, my_nxt, ax, ay;
	logic [AW-1:0]        rd_addr, wr_addr;
	logic                 mem_we, mem_wd;
	logic [SW-1:0]        diff;
	logic [10:0]          half, lim, ds, de;
	logic [14:0]          lhh;
	logic [15:0]          de_full;
	logic [CW:0]          start_x, start_y;
	logic                 wr_cmd;

	assign cols_eff = (cfg.cols == '0) ? 13'd1 : cfg.cols;
	assign rows_eff = (cfg.rows == '0) ? 12'd1 : cfg.rows;

	gdrc_div #(.W(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quotient (div_q)
	);

	assign magx = rdx_q[31] ? 32'(-rdx_q) : 32'(rdx_q);
	assign magy = rdy_q[31] ? 32'(-rdy_q) : 32'(rdy_q);

	always_comb begin
		div_go = 1'b0;
		div_a  = {4'b0, q_item.column, 15'b0};
		div_b  = {18'b0, cols_eff};
		case (state_q)
			S_IDLE: div_go = q_valid && (q_item.cmd == gdrc_pkg::CMD_CAST);
			S_DX: begin
				div_go = (rdx_q != '0);
				div_a  = DW'(1) << 30;
				div_b  = magx[DW-1:0];
			end
			S_DY: begin
				div_go = (rdy_q != '0);
				div_a  = DW'(1) << 30;
				div_b  = magy[DW-1:0];
			end
			S_LH: begin
				div_go = (perp_q != '0);
				div_a  = {11'b0, rows_eff, 8'b0};
				div_b  = {15'b0, perp_q};
			end
			default: ;
		endcase
	end

	// distance from the start point to the first cell edge, Q1.10
	assign fracx  = nx_q ? {1'b0, cfg.player_x[9:0]} : 11'd1024 - {1'b0, cfg.player_x[9:0]};
	assign fracy  = ny_q ? {1'b0, cfg.player_y[9:0]} : 11'd1024 - {1'b0, cfg.player_y[9:0]};
	assign sprodx = 42'(fracx) * 42'(dx_q[30:0]);
	assign sprody = 42'(fracy) * 42'(dy_q[30:0]);
	assign sidex  = (rdx_q == '0) ? SW'({fracx, 30'b0}) : SW'(sprodx >> 10);
	assign sidey  = (rdy_q == '0) ? SW'({fracy, 30'b0}) : SW'(sprody >> 10);

	assign start_x = (CW+1)'(cfg.player_x[15:10]);
	assign start_y = (CW+1)'(cfg.player_y[15:10]);

	// one DDA step: nearer side crossing, y on ties
	assign x_first = sx_q < sy_q;
	assign x_out   = nx_q ? (mx_q == '0) : (mx_q == CW'(MAP_SIDE - 1));
	assign y_out   = ny_q ? (my_q == '0) : (my_q == CW'(MAP_SIDE - 1));
	assign mx_nxt  = nx_q ? mx_q - 1'b1 : mx_q + 1'b1;
	assign my_nxt  = ny_q ? my_q - 1'b1 : my_q + 1'b1;
	assign ax      = x_first ? mx_nxt : mx_q;
	assign ay      = x_first ? my_q : my_nxt;
	assign rd_addr = AW'(32'(ay) * MAP_SIDE + 32'(ax));

	assign wr_cmd = (state_q == S_IDLE) && q_valid && (q_item.cmd == gdrc_pkg::CMD_WRITE);
	always_comb begin
		if (state_q == S_CLR) begin
			mem_we  = 1'b1;
			wr_addr = clr_q;
			mem_wd  = 1'b0;
		end else begin
			mem_we  = wr_cmd && (32'(q_item.cell_x) < MAP_SIDE)
				&& (32'(q_item.cell_y) < MAP_SIDE);
			wr_addr = AW'(32'(q_item.cell_y) * MAP_SIDE + 32'(q_item.cell_x));
			mem_wd  = q_item.wall;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) map_q[wr_addr] <= mem_wd;
		rdata_q <= map_q[rd_addr];
	end

	assign diff    = horiz_q ? sy_q - dy_q : sx_q - dx_q;
	assign half    = rows_eff[11:1];
	assign lhh     = lh_q[15:1];
	assign ds      = (lhh >= 15'(half)) ? 11'd0 : half - lhh[10:0];
	assign de_full = 16'(half) + 16'(lhh);
	assign lim     = (rows_eff > 12'd2047) ? 11'd2047 : 11'(rows_eff - 12'd1);
	assign de      = (de_full > 16'(lim)) ? lim : de_full[10:0];

	assign q_pop = (state_q == S_IDLE) && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1)) state_q <= S_IDLE;
				end
				S_IDLE: if (q_valid && q_item.cmd == gdrc_pkg::CMD_CAST) state_q <= S_CAM;
				S_CAM:  if (div_done) state_q <= S_MUL;
				S_MUL:  state_q <= S_RAY;
				S_RAY:  state_q <= S_DX;
				S_DX:   state_q <= (rdx_q != '0) ? S_DXW : S_DY;
				S_DXW:  if (div_done) state_q <= S_DY;
				S_DY:   state_q <= (rdy_q != '0) ? S_DYW : S_SIDE;
				S_DYW:  if (div_done) state_q <= S_SIDE;
				S_SIDE: begin
					if (start_x >= (CW+1)'(MAP_SIDE) || start_y >= (CW+1)'(MAP_SIDE))
						state_q <= S_PERP;
					else
						state_q <= S_STEP;
				end
				S_STEP: state_q <= ((x_first && x_out) || (!x_first && y_out)) ? S_PERP : S_TEST;
				S_TEST: if (rdata_q || n_q == NW'(MAX_STEPS)) state_q <= S_PERP;
					else state_q <= S_STEP;
				S_PERP: state_q <= S_LH;
				S_LH:   state_q <= (perp_q != '0) ? S_LHW : S_OUT;
				S_LHW:  if (div_done) state_q <= S_OUT;
				S_OUT: begin
					res_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_CAM: if (div_done) cam_q <= $signed({1'b0, div_q[27:0]}) - 29'sd16384;
			S_MUL: begin
				prodx_q <= cfg.plane_x * cam_q;
				prody_q <= cfg.plane_y * cam_q;
			end
			S_RAY: begin
				rdx_q <= 32'(cfg.dir_x) + 32'(prodx_q >>> 14);
				rdy_q <= 32'(cfg.dir_y) + 32'(prody_q >>> 14);
			end
			S_DX: begin
				nx_q <= rdx_q[31];
				if (rdx_q == '0) dx_q <= ZERO_DELTA;
			end
			S_DXW: if (div_done) dx_q <= SW'(div_q);
			S_DY: begin
				ny_q <= rdy_q[31];
				if (rdy_q == '0) dy_q <= ZERO_DELTA;
			end
			S_DYW: if (div_done) dy_q <= SW'(div_q);
			S_SIDE: begin
				sx_q      <= sidex;
				sy_q      <= sidey;
				mx_q      <= CW'(cfg.player_x[15:10]);
				my_q      <= CW'(cfg.player_y[15:10]);
				n_q       <= '0;
				horiz_q   <= 1'b0;
				stepped_q <= 1'b0;
				left_q    <= 1'b1;
			end
			S_STEP: begin
				stepped_q <= 1'b1;
				n_q       <= n_q + 1'b1;
				if (x_first) begin
					sx_q    <= sx_q + dx_q;
					horiz_q <= 1'b0;
					if (!x_out) mx_q <= mx_nxt;
				end else begin
					sy_q    <= sy_q + dy_q;
					horiz_q <= 1'b1;
					if (!y_out) my_q <= my_nxt;
				end
			end
			S_TEST: left_q <= !rdata_q;
			S_PERP: begin
				if (!stepped_q) perp_q <= '0;
				else if (|diff[SW-1:24]) perp_q <= 16'hFFFF;
				else perp_q <= diff[23:8];
			end
			S_LH: if (perp_q == '0) lh_q <= 16'hFFFF;
			S_LHW: if (div_done) lh_q <= (|div_q[DW-1:16]) ? 16'hFFFF : div_q[15:0];
			S_OUT: begin
				res_q.perp  <= perp_q;
				res_q.hit_x <= mx_q[5:0];
				res_q.hit_y <= my_q[5:0];
				res_q.horiz <= horiz_q;
				res_q.neg_x <= nx_q;
				res_q.neg_y <= ny_q;
				res_q.lh    <= lh_q;
				res_q.ds    <= ds;
				res_q.de    <= de;
				res_q.left  <= left_q;
			end
			default: ;
		endcase
	end

	assign clearing  = (state_q == S_CLR);
	assign res       = res_q;
	assign res_valid = res_valid_q;
endmodule

### hdl/grid_dda_ray_caster_unit.sv
// Top level of the grid DDA ray caster: APB register file, front queue, cast engine.
// Depends on gdrc_pkg, gdrc_front, gdrc_back (and gdrc_div below it).
//
// Usage
//  - Command beat: taken at a rising edge with start high and busy low. cmd 0 writes
//    one wall map cell (cell_x, cell_y, cell_is_wall) and gives no result; cmd 1 casts
//    the ray for screen column `column` and gives one result beat.
//  - Result beat: result_valid is high for exactly one cycle with all result ports
//    valid in that cycle. The receiver cannot stall; results are never held back.
//  - A two-entry queue sits between the command port and the cast engine, so up to
//    two beats are taken while a cast is still running; busy rises when it is full.
//  - The idle engine pops each beat; a map write is done as it is popped. A cast then
//    divides for camera x, forms the ray and its two step deltas, and walks grid cells
//    (one step state and one map read state each, up to MAX_STEPS) before distance and
//    line height. Four serial divisions (camera x, two step deltas, line height) use
//    one divider; the delta and height divisions are skipped for a zero ray component
//    or distance. The 1-bit-per-cycle divider and one map read port set the cast time.
//  - Reset: registers return to their defaults; the map is then cleared by a sweep of
//    all MAP_SIDE*MAP_SIDE cells (4096 by default) with busy held high. Register
//    writes are taken during the sweep; the block does not enforce idle-only writes.
//  - Registers: word i at byte address 4*i; write them only while the block is idle.
module grid_dda_ray_caster_unit #(
	parameter int MAP_SIDE  = gdrc_pkg::MAP_SIDE_DEF,
	parameter int MAX_STEPS = gdrc_pkg::MAX_STEPS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// APB configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [gdrc_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	// command channel
	input  logic                        start,
	output logic                        busy,
	input  logic                        cmd,
	input  logic [11:0]                 column,
	input  logic [5:0]                  cell_x,
	input  logic [5:0]                  cell_y,
	input  logic                        cell_is_wall,
	// result channel
	output logic                        result_valid,
	output logic [15:0]                 perp_distance,
	output logic [5:0]                  hit_x,
	output logic [5:0]                  hit_y,
	output logic                        hit_horizontal,
	output logic                        step_x_negative,
	output logic                        step_y_negative,
	output logic [15:0]                 line_height,
	output logic [10:0]                 slice_top,
	output logic [10:0]                 slice_bottom,
	output logic                        left_map
);
	gdrc_pkg::cfg_t  cfg_q;
	gdrc_pkg::item_t in_item, q_item;
	gdrc_pkg::res_t  res;
	logic            q_valid, q_pop, clearing;
	logic            reg_wr;
	logic [2:0]      reg_idx;

	// register file
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign reg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.player_x <= gdrc_pkg::RST_PLAYER_X;
			cfg_q.player_y <= gdrc_pkg::RST_PLAYER_Y;
			cfg_q.dir_x    <= gdrc_pkg::RST_DIR_X;
			cfg_q.dir_y    <= gdrc_pkg::RST_DIR_Y;
			cfg_q.plane_x  <= gdrc_pkg::RST_PLANE_X;
			cfg_q.plane_y  <= gdrc_pkg::RST_PLANE_Y;
			cfg_q.cols     <= gdrc_pkg::RST_COLS;
			cfg_q.rows     <= gdrc_pkg::RST_ROWS;
		end else if (reg_wr) begin
			case (reg_idx)
				gdrc_pkg::REG_PLAYER_X: cfg_q.player_x <= pwdata[15:0];
				gdrc_pkg::REG_PLAYER_Y: cfg_q.player_y <= pwdata[15:0];
				gdrc_pkg::REG_DIR_X:    cfg_q.dir_x    <= pwdata[15:0];
				gdrc_pkg::REG_DIR_Y:    cfg_q.dir_y    <= pwdata[15:0];
				gdrc_pkg::REG_PLANE_X:  cfg_q.plane_x  <= pwdata[15:0];
				gdrc_pkg::REG_PLANE_Y:  cfg_q.plane_y  <= pwdata[15:0];
				gdrc_pkg::REG_COLS:     cfg_q.cols     <= pwdata[12:0];
				gdrc_pkg::REG_ROWS:     cfg_q.rows     <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			gdrc_pkg::REG_PLAYER_X: prdata = {16'b0, cfg_q.player_x};
			gdrc_pkg::REG_PLAYER_Y: prdata = {16'b0, cfg_q.player_y};
			gdrc_pkg::REG_DIR_X:    prdata = {16'b0, cfg_q.dir_x};
			gdrc_pkg::REG_DIR_Y:    prdata = {16'b0, cfg_q.dir_y};
			gdrc_pkg::REG_PLANE_X:  prdata = {16'b0, cfg_q.plane_x};
			gdrc_pkg::REG_PLANE_Y:  prdata = {16'b0, cfg_q.plane_y};
			gdrc_pkg::REG_COLS:     prdata = {19'b0, cfg_q.cols};
			gdrc_pkg::REG_ROWS:     prdata = {20'b0, cfg_q.rows};
			default:                prdata = 32'b0;
		endcase
	end

	// command beat into the front queue
	assign in_item.cmd    = cmd;
	assign in_item.column = column;
	assign in_item.cell_x = cell_x;
	assign in_item.cell_y = cell_y;
	assign in_item.wall   = cell_is_wall;

	gdrc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.in_item (in_item),
		.hold    (clearing),
		.busy    (busy),
		.q_item  (q_item),
		.q_valid (q_valid),
		.q_pop   (q_pop)
	);

	gdrc_back #(
		.MAP_SIDE  (MAP_SIDE),
		.MAX_STEPS (MAX_STEPS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_item    (q_item),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.clearing  (clearing),
		.res       (res),
		.res_valid (result_valid)
	);

	// result beat, registered in the engine
	assign perp_distance   = res.perp;
	assign hit_x           = res.hit_x;
	assign hit_y           = res.hit_y;
	assign hit_horizontal  = res.horiz;
	assign step_x_negative = res.neg_x;
	assign step_y_negative = res.neg_y;
	assign line_height     = res.lh;
	assign slice_top       = res.ds;
	assign slice_bottom    = res.de;
	assign left_map        = res.left;
endmodule

### bench/tb.sv
// Self-checking bench for grid_dda_ray_caster_unit: random bursts of map writes and casts.
// Depends on gdrc_pkg and the block under hdl/; predicts every cast and checks each result beat.
`timescale 1ns / 100ps

module tb;

	localparam int LIMIT = 20000;   // idle cycles before giving up, allowing for the reset sweep
	localparam int SETTLE = 40;     // cycles for queued map writes to drain

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [gdrc_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic start = 1'b0;
	logic busy;
	logic cmd = 1'b0;
	logic [11:0] column = '0;
	logic [5:0] cell_x = '0, cell_y = '0;
	logic cell_is_wall = 1'b0;
	logic result_valid;
	logic [15:0] perp_distance, line_height;
	logic [5:0] hit_x, hit_y;
	logic hit_horizontal, step_x_negative, step_y_negative, left_map;
	logic [10:0] slice_top, slice_bottom;

	grid_dda_ray_caster_unit uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow of the block: registers and the wall bitmap, updated in accept order.
	gdrc_pkg::cfg_t shadow_cfg;
	bit wall_bits [4096];
	gdrc_pkg::item_t cmd_fifo [$];
	gdrc_pkg::res_t hits_due [$];
	int errors = 0;
	int idle_cycles = 0;

	// Per-axis setup: step sign, Q16.16 delta and distance to the first cell edge.
	function automatic void axis_setup(input longint rd, input longint pos, output bit neg,
			output longint delta, output longint side);
		longint mag, cidx, frac;
		neg = rd < 0;
		mag = neg ? -rd : rd;
		cidx = pos >> 10;
		delta = (mag != 0) ? ((longint'(1) << 30) / mag) : (longint'(1) << 40);
		frac = neg ? pos - (cidx << 10) : ((cidx + 1) << 10) - pos;
		side = (frac * delta) >> 10;
	endfunction

	function automatic gdrc_pkg::res_t cast_ray(input logic [11:0] col);
		gdrc_pkg::res_t r;
		longint cols, rows, cam, rdx, rdy, dx, dy, sx, sy, mx, my, t;
		longint perp, lh, half, ds, de, lim;
		bit nx, ny, horiz, left, hit, stepped;
		cols = (shadow_cfg.cols != 0) ? shadow_cfg.cols : 1;
		rows = (shadow_cfg.rows != 0) ? shadow_cfg.rows : 1;
		cam = ((longint'(col) << 15) / cols) - 16384;
		// >>> on a signed value floors, matching the Q2.14 product rounding
		rdx = longint'($signed(shadow_cfg.dir_x))
			+ ((longint'($signed(shadow_cfg.plane_x)) * cam) >>> 14);
		rdy = longint'($signed(shadow_cfg.dir_y))
			+ ((longint'($signed(shadow_cfg.plane_y)) * cam) >>> 14);
		mx = shadow_cfg.player_x >> 10;
		my = shadow_cfg.player_y >> 10;
		axis_setup(rdx, shadow_cfg.player_x, nx, dx, sx);
		axis_setup(rdy, shadow_cfg.player_y, ny, dy, sy);
		horiz = 0; left = 0; hit = 0; stepped = 0;
		if (mx >= gdrc_pkg::MAP_SIDE_DEF || my >= gdrc_pkg::MAP_SIDE_DEF) begin
			left = 1;
		end else begin
			for (int n = 0; n < gdrc_pkg::MAX_STEPS_DEF; n++) begin
				stepped = 1;
				if (sx < sy) begin
					t = mx + (nx ? -1 : 1);
					sx += dx;
					horiz = 0;
					if (t < 0 || t >= gdrc_pkg::MAP_SIDE_DEF) begin
						left = 1;
						break;
					end
					mx = t;
				end else begin
					// ties (both deltas saturated included) go to y
					t = my + (ny ? -1 : 1);
					sy += dy;
					horiz = 1;
					if (t < 0 || t >= gdrc_pkg::MAP_SIDE_DEF) begin
						left = 1;
						break;
					end
					my = t;
				end
				if (wall_bits[my * gdrc_pkg::MAP_SIDE_DEF + mx]) begin
					hit = 1;
					break;
				end
			end
			if (!hit)
				left = 1;
		end
		perp = stepped ? ((horiz ? sy - dy : sx - dx) >> 8) : 0;
		if (perp > 65535)
			perp = 65535;
		lh = (perp == 0) ? 65535 : (rows << 8) / perp;
		if (lh > 65535)
			lh = 65535;
		half = rows / 2;
		ds = (lh / 2 >= half) ? 0 : half - lh / 2;
		de = half + lh / 2;
		lim = (rows - 1 > 2047) ? 2047 : rows - 1;
		if (de > lim)
			de = lim;
		r.perp = perp[15:0];
		r.hit_x = mx[5:0];
		r.hit_y = my[5:0];
		r.horiz = horiz;
		r.neg_x = nx;
		r.neg_y = ny;
		r.lh = lh[15:0];
		r.ds = ds[10:0];
		r.de = de[10:0];
		r.left = left;
		return r;
	endfunction

	// Driver: bursts of random length, random gaps, some long gap-free stretches.
	int burst_left = 0, gap_left = 0;
	always @(posedge clk) begin
		bit go;
		gdrc_pkg::item_t nxt;
		if (start && !busy) begin
			nxt = cmd_fifo.pop_front();
			if (nxt.cmd == gdrc_pkg::CMD_CAST)
				hits_due.push_back(cast_ray(nxt.column));
			else
				wall_bits[nxt.cell_y * gdrc_pkg::MAP_SIDE_DEF + nxt.cell_x] = nxt.wall;
		end
		go = 0;
		if (gap_left > 0) begin
			gap_left--;
		end else if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
		end else begin
			burst_left--;
			go = 1;
		end
		if (go && cmd_fifo.size() > 0 && arst_n) begin
			nxt = cmd_fifo[0];
			start <= 1'b1;
			cmd <= nxt.cmd;
			column <= nxt.column;
			cell_x <= nxt.cell_x;
			cell_y <= nxt.cell_y;
			cell_is_wall <= nxt.wall;
		end else begin
			start <= 1'b0;
		end
	end

	// Monitor: each result beat is checked against the oldest prediction.
	always @(posedge clk) begin
		gdrc_pkg::res_t want;
		if (result_valid) begin
			if (hits_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result beat at %0t", $realtime);
			end else begin
				want = hits_due.pop_front();
				if (perp_distance !== want.perp || hit_x !== want.hit_x || hit_y !== want.hit_y
						|| hit_horizontal !== want.horiz || step_x_negative !== want.neg_x
						|| step_y_negative !== want.neg_y || line_height !== want.lh
						|| slice_top !== want.ds || slice_bottom !== want.de
						|| left_map !== want.left) begin
					errors++;
					if (errors <= 10) begin
						$display("mismatch at %0t", $realtime);
						$display("  exp perp=%0d hit=(%0d,%0d) h=%0b nx=%0b ny=%0b lh=%0d %0d..%0d left=%0b",
							want.perp, want.hit_x, want.hit_y, want.horiz, want.neg_x,
							want.neg_y, want.lh, want.ds, want.de, want.left);
						$display("  got perp=%0d hit=(%0d,%0d) h=%0b nx=%0b ny=%0b lh=%0d %0d..%0d left=%0b",
							perp_distance, hit_x, hit_y, hit_horizontal, step_x_negative,
							step_y_negative, line_height, slice_top, slice_bottom, left_map);
					end
				end
			end
		end
	end

	// Watchdog on cycles with no beat moving in either direction.
	always @(posedge clk) begin
		if ((start && !busy) || result_valid || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic reg_write(input logic [2:0] idx, input logic [15:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'h0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			gdrc_pkg::REG_PLAYER_X: shadow_cfg.player_x = val;
			gdrc_pkg::REG_PLAYER_Y: shadow_cfg.player_y = val;
			gdrc_pkg::REG_DIR_X:    shadow_cfg.dir_x = val;
			gdrc_pkg::REG_DIR_Y:    shadow_cfg.dir_y = val;
			gdrc_pkg::REG_PLANE_X:  shadow_cfg.plane_x = val;
			gdrc_pkg::REG_PLANE_Y:  shadow_cfg.plane_y = val;
			gdrc_pkg::REG_COLS:     shadow_cfg.cols = val[12:0];
			gdrc_pkg::REG_ROWS:     shadow_cfg.rows = val[11:0];
			default: ;
		endcase
	endtask

	task automatic set_view(input logic [15:0] px, py, dx, dy, qx, qy, cols, rows);
		reg_write(gdrc_pkg::REG_PLAYER_X, px);
		reg_write(gdrc_pkg::REG_PLAYER_Y, py);
		reg_write(gdrc_pkg::REG_DIR_X, dx);
		reg_write(gdrc_pkg::REG_DIR_Y, dy);
		reg_write(gdrc_pkg::REG_PLANE_X, qx);
		reg_write(gdrc_pkg::REG_PLANE_Y, qy);
		reg_write(gdrc_pkg::REG_COLS, cols & 16'h1FFF);
		reg_write(gdrc_pkg::REG_ROWS, rows & 16'h0FFF);
	endtask

	task automatic put_cell(input int x, y, input bit w);
		gdrc_pkg::item_t it;
		it = '0;
		it.cmd = gdrc_pkg::CMD_WRITE;
		it.column = 12'($urandom());   // don't-care on writes, still toggled
		it.cell_x = 6'(x);
		it.cell_y = 6'(y);
		it.wall = w;
		cmd_fifo.push_back(it);
	endtask

	task automatic put_cast(input int col);
		gdrc_pkg::item_t it;
		it = '0;
		it.cmd = gdrc_pkg::CMD_CAST;
		it.column = 12'(col);
		it.cell_x = 6'($urandom());
		it.cell_y = 6'($urandom());
		it.wall = 1'($urandom());
		cmd_fifo.push_back(it);
	endtask

	// Let the block go fully quiet before touching registers again.
	task automatic drain();
		while (cmd_fifo.size() > 0 || hits_due.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		int cx, cy, r, ncast;
		logic [15:0] vc, vr;
		shadow_cfg = {gdrc_pkg::RST_PLAYER_X, gdrc_pkg::RST_PLAYER_Y, gdrc_pkg::RST_DIR_X,
			gdrc_pkg::RST_DIR_Y, gdrc_pkg::RST_PLANE_X, gdrc_pkg::RST_PLANE_Y,
			gdrc_pkg::RST_COLS, gdrc_pkg::RST_ROWS};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset view on empty map, then a wall straight ahead
		put_cast(0); put_cast(320); put_cast(639); put_cast(4095);
		put_cell(40, 32, 1'b1); put_cell(63, 63, 1'b1); put_cell(0, 0, 1'b1);
		put_cast(320); put_cast(100); put_cast(600);
		drain();
		// zero ray in both axes: ties step in y until the map edge
		set_view(16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd0, 16'd0);
		put_cast(0); put_cast(4095);
		drain();
		set_view(16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'd4096, 16'd4095);
		put_cast(0); put_cast(2048); put_cast(4095);
		put_cell(0, 0, 1'b0); put_cell(63, 63, 1'b0);
		put_cast(1000);
		drain();
		set_view(16'(5 * 1024 + 512), 16'(5 * 1024 + 100), 16'h8000, 16'h0000, 16'h0000,
			16'h7FFF, 16'd1, 16'd1);
		put_cell(2, 5, 1'b1); put_cell(5, 9, 1'b1);
		put_cast(0); put_cast(1);
		drain();

		// random phases: a walled room around the player in most, random walls, many casts
		for (int ph = 0; ph < 10; ph++) begin
			cx = $urandom_range(2, 61);
			cy = $urandom_range(2, 61);
			vc = (ph == 3) ? 16'd4096 : (ph == 6) ? 16'd0 : 16'($urandom_range(1, 4096));
			vr = (ph == 4) ? 16'd4095 : (ph == 7) ? 16'd0 : 16'($urandom_range(1, 2048));
			set_view(16'(cx * 1024 + $urandom_range(0, 1023)),
				16'(cy * 1024 + $urandom_range(0, 1023)),
				16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()), vc, vr);
			if (ph % 4 != 3) begin
				r = $urandom_range(2, 6);
				for (int k = -r; k <= r; k++) begin
					put_cell(cx + k < 0 ? 0 : cx + k > 63 ? 63 : cx + k, cy - r < 0 ? 0 : cy - r, 1'b1);
					put_cell(cx + k < 0 ? 0 : cx + k > 63 ? 63 : cx + k, cy + r > 63 ? 63 : cy + r, 1'b1);
					put_cell(cx - r < 0 ? 0 : cx - r, cy + k < 0 ? 0 : cy + k > 63 ? 63 : cy + k, 1'b1);
					put_cell(cx + r > 63 ? 63 : cx + r, cy + k < 0 ? 0 : cy + k > 63 ? 63 : cy + k, 1'b1);
				end
			end
			// noise: a few walls and openings anywhere, keeping the player's own cell open
			for (int k = 0; k < 6; k++)
				put_cell($urandom_range(0, 63), $urandom_range(0, 63), 1'($urandom_range(0, 1)));
			put_cell(cx, cy, 1'b0);
			ncast = 90;
			for (int k = 0; k < ncast; k++) begin
				if ($urandom_range(0, 9) == 0)
					put_cast($urandom_range(0, 4095));
				else
					put_cast($urandom_range(0, shadow_cfg.cols > 1 ? shadow_cfg.cols - 1 : 0));
				if ($urandom_range(0, 15) == 0)
					put_cell($urandom_range(0, 63), $urandom_range(0, 63),
						1'($urandom_range(0, 1)));
			end
			drain();
		end

		if (hits_due.size() != 0)
			errors++;
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### filelist.f
hdl/gdrc_pkg.sv
hdl/gdrc_div.sv
hdl/gdrc_front.sv
hdl/gdrc_back.sv
hdl/grid_dda_ray_caster_unit.sv
bench/tb.sv
